// ===== src/smpq_pkg.sv =====
// Shared types, constants and command/status structs for the sorted priority queue.
`default_nettype none

package smpq_pkg;

  localparam int KEY_W            = 32;
  localparam int STATUS_W         = 2;
  localparam int OCC_W            = 5;
  localparam int DEFAULT_CAPACITY = 16;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } pq_status_t;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } pq_op_t;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_PREV,
    RD_PREV2
  } rd_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SHIFT_CMP,
    S_PLACE,
    S_DEQ_WAIT,
    S_RESULT
  } pq_state_t;

  typedef struct packed {
    logic    in_ready;
    logic    res_init;
    logic    res_take;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_key;
    logic    walk_dec;
    logic    count_inc;
    logic    count_dec;
    logic    head_inc;
    logic    out_load;
  } smpq_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic is_deq;
    logic full;
    logic empty;
    logic walk_is_one;
    logic rd_less;
    logic out_free;
  } smpq_stat_t;

endpackage

`default_nettype wire

// ===== src/smpq_ifs.sv =====
// Request and response channel interfaces of the sorted priority queue.
`default_nettype none

interface smpq_req_if
  import smpq_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [KEY_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface smpq_rsp_if
  import smpq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [KEY_W-1:0]    out_value;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output out_value, output status, output occupancy, input ready);
  modport sink   (input valid, input out_value, input status, input occupancy, output ready);
endinterface

`default_nettype wire

// ===== src/smpq_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module smpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/smpq_ctrl.sv =====
// Control state machine of the sorted priority queue.
`default_nettype none

module smpq_ctrl
  import smpq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire smpq_stat_t stat,
  output smpq_cmd_t       cmd
);

  pq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_HEAD;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.res_init = 1'b1;
        if (stat.is_deq) begin
          if (stat.empty) begin
            state_next = S_RESULT;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_HEAD;
            state_next = S_DEQ_WAIT;
          end
        end else if (stat.full) begin
          state_next = S_RESULT;
        end else if (stat.empty) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_key    = 1'b1;
          cmd.count_inc = 1'b1;
          state_next    = S_RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_next = S_SHIFT_CMP;
        end
      end
      S_SHIFT_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.rd_less) begin
          cmd.wr_key    = 1'b1;
          cmd.count_inc = 1'b1;
          state_next    = S_RESULT;
        end else begin
          // move the entry up one slot and step the walk down
          cmd.walk_dec = 1'b1;
          if (stat.walk_is_one) begin
            state_next = S_PLACE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_PREV2;
          end
        end
      end
      S_PLACE: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_key    = 1'b1;
        cmd.count_inc = 1'b1;
        state_next    = S_RESULT;
      end
      S_DEQ_WAIT: begin
        cmd.res_take  = 1'b1;
        cmd.head_inc  = 1'b1;
        cmd.count_dec = 1'b1;
        state_next    = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/smpq_datapath.sv =====
// Datapath of the sorted priority queue: circular sorted store, counters and output register.
`default_nettype none

module smpq_datapath
  import smpq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic     clk,
  input  wire logic     rst,
  smpq_req_if.sink      req,
  smpq_rsp_if.source    rsp,
  input  wire smpq_cmd_t cmd,
  output smpq_stat_t    stat
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [SUM_W-1:0] CAP_SUM  = SUM_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  logic             opcode;
  logic [KEY_W-1:0] key;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] walk;
  logic [IDX_W-1:0] head;

  logic [KEY_W-1:0]    res_value;
  pq_status_t          res_status;

  logic                out_valid;
  logic [KEY_W-1:0]    out_value;
  logic [STATUS_W-1:0] out_status;
  logic [OCC_W-1:0]    out_occ;

  logic             accept;
  logic [CNT_W-1:0] rd_logical;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic [KEY_W-1:0] rd_data;

  // Map a logical slot (0 = smallest) onto the circular store.
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] hd,
                                            input logic [CNT_W-1:0] lg);
    logic [SUM_W-1:0] sum;
    begin
      sum = SUM_W'(hd) + SUM_W'(lg);
      if (sum >= CAP_SUM) begin
        sum = sum - CAP_SUM;
      end
      phys = sum[IDX_W-1:0];
    end
  endfunction

  assign accept = req.valid && req.ready;

  always_comb begin
    case (cmd.rd_sel)
      RD_PREV:  rd_logical = walk - CNT_W'(1);
      RD_PREV2: rd_logical = walk - CNT_W'(2);
      default:  rd_logical = '0;
    endcase
  end

  assign rd_addr = phys(head, rd_logical);
  assign wr_addr = phys(head, walk);
  assign wr_data = cmd.wr_key ? key : rd_data;

  smpq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Request capture and walk pointer.
  always_ff @(posedge clk) begin
    if (accept) begin
      opcode <= req.opcode;
      key    <= req.value;
    end
    if (accept) begin
      walk <= count;
    end else if (cmd.walk_dec) begin
      walk <= walk - CNT_W'(1);
    end
  end

  // Occupancy and head pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      head  <= '0;
    end else begin
      if (cmd.count_inc) begin
        count <= count + CNT_W'(1);
      end else if (cmd.count_dec) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.head_inc) begin
        head <= (head == LAST_IDX) ? '0 : head + IDX_W'(1);
      end
    end
  end

  // Result held until the output register is free.
  always_ff @(posedge clk) begin
    if (cmd.res_init) begin
      res_value <= '0;
      if (opcode == OP_DEQ) begin
        res_status <= (count == '0) ? ST_EMPTY : ST_OK;
      end else begin
        res_status <= (count == CAP_CNT) ? ST_FULL : ST_OK;
      end
    end else if (cmd.res_take) begin
      res_value <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value  <= res_value;
      out_status <= res_status;
      out_occ    <= OCC_W'(count);
    end
  end

  assign req.ready     = cmd.in_ready;
  assign rsp.valid     = out_valid;
  assign rsp.out_value = out_value;
  assign rsp.status    = out_status;
  assign rsp.occupancy = out_occ;

  assign stat.in_valid    = req.valid;
  assign stat.is_deq      = (opcode == OP_DEQ);
  assign stat.full        = (count == CAP_CNT);
  assign stat.empty       = (count == '0);
  assign stat.walk_is_one = (walk == CNT_W'(1));
  assign stat.rd_less     = $signed(rd_data) < $signed(key);
  assign stat.out_free    = !out_valid || rsp.ready;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CAP_CNT)
    else $error("occupancy beyond capacity");
  a_head_bound: assert property (@(posedge clk) disable iff (rst) head <= LAST_IDX)
    else $error("head pointer out of range");
  a_inc_step: assert property (@(posedge clk) disable iff (rst)
    cmd.count_inc |=> count == $past(count) + CNT_W'(1))
    else $error("occupancy did not advance by one on insert");
  a_no_inc_full: assert property (@(posedge clk) disable iff (rst)
    cmd.count_inc |-> count != CAP_CNT)
    else $error("insert into a full store");
  a_no_dec_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.count_dec |-> count != '0)
    else $error("removal from an empty store");
`endif

endmodule

`default_nettype wire

// ===== src/sorted_min_priority_queue.sv =====
// Sorted minimum-priority queue: top level joining controller and datapath.
`default_nettype none

// Bounded min-priority queue of signed 32-bit keys, held in ascending order in a
// CAPACITY-entry circular RAM. Each request beat is one enqueue (opcode 0) or one
// dequeue (opcode 1), and each gives exactly one response beat carrying the
// dequeued key (zero otherwise), a status (ok, dequeue on empty, enqueue on full
// dropped) and the occupancy after the request, modulo 32. A new key goes ahead
// of any equal keys already held. Requests are served one at a time: a dequeue
// reads the head slot through the RAM's registered read port; an enqueue walks
// down from the tail, reading one entry and writing it one slot up each cycle,
// until it meets a held key smaller than the new one or the bottom slot. An
// enqueue into an empty queue writes the key directly, and a rejected request
// goes straight to the result. The next request is taken as soon as the result
// is in the output register, even while the response beat still waits.
module sorted_min_priority_queue
  import smpq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic  clk,
  input  wire logic  rst,
  smpq_req_if.sink   req,
  smpq_rsp_if.source rsp
);

  smpq_cmd_t  cmd;
  smpq_stat_t stat;

  // Sequencer: dispatch, tail walk for inserts, head read for removals.
  smpq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // Store, pointers, occupancy and the output register.
  smpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

`default_nettype wire
